/* design/pil_pkg.sv */
// Package for the positional integer list: sizes, command and status codes, word types.
`default_nettype none

package pil_pkg;

   // Number of entries the list can hold.
   localparam int unsigned CAPACITY = 64;

   // Field widths fixed by the word format.
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned LEN_W   = 7;

   // Internal widths that follow from the capacity.
   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [VALUE_W-1:0]  value;
      logic        [POS_W-1:0]    position;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  found_at;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
   } rsp_word_type;

endpackage : pil_pkg

`default_nettype wire

/* design/pil_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module pil_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : pil_ram

`default_nettype wire

/* design/positional_integer_list.sv */
// Top level of the positional integer list: command sequencer around one entry RAM.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit integers in one RAM
// (one write port, one registered read port). A command word is taken when
// start is high and busy is low; exactly one result word follows, shown on
// rsp_word for a single cycle with rsp_valid high. The receiver cannot stall,
// so capture rsp_word whenever rsp_valid is set. What each command does:
//   clear, and any insert/delete refused for a bad position or a full list:
//     busy never rises, so a new command can go in back to back.
//   insert at position p into a list of n entries: entries p .. n shift up
//     by one first; nothing to shift for an append (p = n + 1).
//   delete at position p from n entries: entries p + 1 .. n shift down by one;
//     nothing to shift for the tail entry (p = n).
//   search over n entries: reads from position 1 up and stops at the first
//     match, or after all n entries on a miss; an empty list is not read.
// The longest command is a search that misses on a full list. The pace is set
// by the single RAM read port: shifting or scanning moves one entry per cycle,
// with the write of each moved entry in the cycle after its read. The RAM
// needs no clearing after reset; only slots below the entry count are
// ever read.
`default_nettype none

module positional_integer_list (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pil_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   output pil_pkg::rsp_word_type      rsp_word
);

   import pil_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_INSERT = 4'b0010,
      S_DELETE = 4'b0100,
      S_SEARCH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;     // entries in the list
   logic [CNT_W-1:0]   moves_ff, moves_in;     // reads still to issue
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in; // next read address
   logic               pend_ff, pend_in;       // read data arrives this cycle
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0]  ins_addr_ff, ins_addr_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // RAM port signals
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   // Command completion, folded into the result word below
   logic               done;
   status_type         done_status;
   logic [POS_W-1:0]   done_found;

   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;

   pil_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pos_ext = CMP_W'(req_word.position);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      moves_in     = moves_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      ins_addr_in  = ins_addr_ff;
      value_in     = value_ff;

      ram_we    = 1'b0;
      ram_waddr = pend_addr_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = rd_addr_ff;

      done        = 1'b0;
      done_status = ST_OK;
      done_found  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = $unsigned(req_word.value);
               unique case (req_word.command)
                  CMD_INSERT: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                        done        = 1'b1;
                        done_status = ST_RANGE;
                     end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                        done        = 1'b1;
                        done_status = ST_FULL;
                     end else begin
                        // move slots pos-1 .. count-1 back by one, top first
                        ins_addr_in = ADDR_W'(pos_ext - CMP_W'(1));
                        moves_in    = CNT_W'(cnt_ext + CMP_W'(1) - pos_ext);
                        rd_addr_in  = ADDR_W'(cnt_ext - CMP_W'(1));
                        state_in    = S_INSERT;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        done        = 1'b1;
                        done_status = ST_RANGE;
                     end else begin
                        // move slots pos .. count-1 forward by one, bottom first
                        moves_in   = CNT_W'(cnt_ext - pos_ext);
                        rd_addr_in = ADDR_W'(pos_ext);
                        state_in   = S_DELETE;
                     end
                  end
                  CMD_SEARCH: begin
                     moves_in   = count_ff;
                     rd_addr_in = '0;
                     state_in   = S_SEARCH;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         S_INSERT: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (moves_ff != '0) begin
               ram_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr_ff + ADDR_W'(1);
               rd_addr_in   = rd_addr_ff - ADDR_W'(1);
               moves_in     = moves_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               // shift drained: drop the new value into its slot
               ram_we    = 1'b1;
               ram_waddr = ins_addr_ff;
               ram_wdata = value_ff;
               count_in  = count_ff + CNT_W'(1);
               done      = 1'b1;
               state_in  = S_IDLE;
            end
         end

         S_DELETE: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (moves_ff != '0) begin
               ram_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr_ff - ADDR_W'(1);
               rd_addr_in   = rd_addr_ff + ADDR_W'(1);
               moves_in     = moves_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (pend_ff && ram_rdata == value_ff) begin
               // first match wins; reads in flight are dropped
               done       = 1'b1;
               done_found = POS_W'(CNT_W'(pend_addr_ff) + CNT_W'(1));
               state_in   = S_IDLE;
            end else if (moves_ff != '0) begin
               ram_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr_ff;
               rd_addr_in   = rd_addr_ff + ADDR_W'(1);
               moves_in     = moves_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result word reports the length after the command
      rsp_valid_in         = done;
      rsp_word_in          = rsp_word_ff;
      if (done) begin
         rsp_word_in.status   = done_status;
         rsp_word_in.found_at = done_found;
         rsp_word_in.length   = LEN_W'(count_in);
         rsp_word_in.is_empty = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      moves_ff     <= moves_in;
      rd_addr_ff   <= rd_addr_in;
      pend_addr_ff <= pend_addr_in;
      ins_addr_ff  <= ins_addr_in;
      value_ff     <= value_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule : positional_integer_list

`default_nettype wire
